[rtl/sfc_pkg.sv]
// Shared types, constants and functions of the stored frame checker.
`default_nettype none

package sfc_pkg;

  // Record layout and default payload bound.
  localparam int MAX_PAYLOAD_DEF = 4085;
  localparam int HEADER_BYTES    = 11;
  localparam int MAGIC_BYTES     = 5;

  // Reflected CRC-32 constants.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Configuration register.
  localparam int          CAP_W     = 13;
  localparam logic [12:0] CAP_RESET = 13'd4096;
  localparam int          PADDR_W   = 3;
  localparam int          PDATA_W   = 32;

  // Register index of the destination capacity.
  localparam logic REG_DEST_CAPACITY = 1'b0;

  // Status codes reported on the last byte of a record.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SIZE    = 3'd1;
  localparam logic [2:0] ST_HEADER  = 3'd2;
  localparam logic [2:0] ST_LENGTH  = 3'd3;
  localparam logic [2:0] ST_NO_ROOM = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;

  // One result item.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [11:0] payload_offset;
    logic        done_res;
    logic [2:0]  status;
    logic [11:0] payload_length;
  } sfc_res_t;

  // Expected header byte at positions 0 to 4: the magic and the version.
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h53;
      3'd1:    b = 8'h4D;
      3'd2:    b = 8'h4B;
      3'd3:    b = 8'h4D;
      3'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One byte of a reflected CRC-32 update, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/sfc_if.sv]
// Item channel interfaces of the stored frame checker.
`default_nettype none

// Input channel: one record byte per item.
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

// Output channel: one result item per accepted byte.
interface sfc_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [11:0] payload_offset;
  logic        done_res;
  logic [2:0]  status;
  logic [11:0] payload_length;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_offset, output done_res, output status,
                  output payload_length, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input payload_offset, input done_res, input status,
                input payload_length, output ready);
endinterface

`default_nettype wire

[rtl/sfc_core.sv]
// Per-record state of the checker and the result logic for one byte.
`default_nettype none

module sfc_core #(
  parameter int MAX_PAYLOAD = sfc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     last,
  input  wire logic [sfc_pkg::CAP_W-1:0] dest_capacity,
  output sfc_pkg::sfc_res_t             res
);

  localparam int FRAME_MAX = sfc_pkg::HEADER_BYTES + MAX_PAYLOAD;
  localparam int POS_W     = $clog2(FRAME_MAX + 1);
  // Wide enough for header plus a 16-bit length.
  localparam int CMP_W     = 18;

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             header_bad, header_bad_next;
  logic             frame_too_long, frame_too_long_next;
  logic [15:0]      length_field, length_field_next;
  logic [31:0]      expected_crc, expected_crc_next;
  logic [31:0]      running_crc, running_crc_next;

  logic [POS_W-1:0] offset;
  logic [CMP_W-1:0] offset_w;
  logic [CMP_W-1:0] len_w;
  logic [CMP_W-1:0] len_next_w;
  logic [CMP_W-1:0] flen_w;
  logic [CMP_W-1:0] cap_w;
  logic [1:0]       crc_lane;
  logic [31:0]      crc_upd;
  logic [2:0]       status_v;

  assign offset     = byte_position - POS_W'(sfc_pkg::HEADER_BYTES);
  assign offset_w   = CMP_W'(offset);
  assign len_w      = CMP_W'(length_field);
  assign cap_w      = CMP_W'(dest_capacity);
  // Positions 7 to 10 hold the stored CRC; the low two bits plus one give its byte lane.
  assign crc_lane   = byte_position[1:0] + 2'd1;
  assign crc_upd    = sfc_pkg::crc_byte(running_crc, data_byte);

  // Field capture, CRC update, forwarding and the end-of-record status.
  always_comb begin
    byte_position_next  = byte_position;
    header_bad_next     = header_bad;
    frame_too_long_next = frame_too_long;
    length_field_next   = length_field;
    expected_crc_next   = expected_crc;
    running_crc_next    = running_crc;
    res                 = '0;
    status_v            = sfc_pkg::ST_OK;

    if (byte_position >= POS_W'(FRAME_MAX)) begin
      // The position saturates; the record is marked as too long.
      frame_too_long_next = 1'b1;
    end else begin
      if (byte_position < POS_W'(sfc_pkg::MAGIC_BYTES)) begin
        if (data_byte != sfc_pkg::magic_byte(byte_position[2:0])) begin
          header_bad_next = 1'b1;
        end
      end else if (byte_position == POS_W'(5)) begin
        length_field_next[7:0] = data_byte;
      end else if (byte_position == POS_W'(6)) begin
        length_field_next[15:8] = data_byte;
      end else if (byte_position < POS_W'(sfc_pkg::HEADER_BYTES)) begin
        expected_crc_next[crc_lane*8 +: 8] = data_byte;
      end else if (offset_w < len_w) begin
        // Below the frame bound the offset is always under the payload limit.
        running_crc_next = crc_upd;
        if (!header_bad && len_w <= CMP_W'(MAX_PAYLOAD) &&
            len_w + CMP_W'(1) <= cap_w) begin
          res.payload_valid  = 1'b1;
          res.payload_byte   = data_byte;
          res.payload_offset = offset_w[11:0];
        end
      end
      byte_position_next = byte_position + POS_W'(1);
    end

    // Frame length including this byte, and the payload length field from the header.
    flen_w     = CMP_W'(byte_position_next);
    len_next_w = CMP_W'(length_field_next);

    if (last) begin
      if (frame_too_long_next || flen_w < CMP_W'(sfc_pkg::HEADER_BYTES)) begin
        status_v = sfc_pkg::ST_SIZE;
      end else if (header_bad_next) begin
        status_v = sfc_pkg::ST_HEADER;
      end else if (len_next_w > CMP_W'(MAX_PAYLOAD) ||
                   CMP_W'(sfc_pkg::HEADER_BYTES) + len_next_w > flen_w) begin
        status_v = sfc_pkg::ST_LENGTH;
      end else if (len_next_w + CMP_W'(1) > cap_w) begin
        status_v = sfc_pkg::ST_NO_ROOM;
      end else if ((running_crc_next ^ sfc_pkg::CRC_INIT) != expected_crc_next) begin
        status_v = sfc_pkg::ST_CRC;
      end
      res.done_res = 1'b1;
      res.status   = status_v;
      if (status_v == sfc_pkg::ST_OK) begin
        res.payload_length = length_field_next[11:0];
      end
      // The next byte starts a fresh record.
      byte_position_next  = '0;
      header_bad_next     = 1'b0;
      frame_too_long_next = 1'b0;
      length_field_next   = '0;
      expected_crc_next   = '0;
      running_crc_next    = sfc_pkg::CRC_INIT;
    end
  end

  // Record state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      header_bad     <= 1'b0;
      frame_too_long <= 1'b0;
      length_field   <= '0;
      expected_crc   <= '0;
      running_crc    <= sfc_pkg::CRC_INIT;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      header_bad     <= header_bad_next;
      frame_too_long <= frame_too_long_next;
      length_field   <= length_field_next;
      expected_crc   <= expected_crc_next;
      running_crc    <= running_crc_next;
    end
  end

  // A last byte leaves the record state cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> byte_position == '0 && running_crc == sfc_pkg::CRC_INIT &&
                       !header_bad && !frame_too_long)
    else $error("record state not cleared after last byte");

  // The position never passes the frame bound.
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_W'(FRAME_MAX))
    else $error("byte position beyond frame bound");

  // The too-long mark is only set once the position has saturated.
  a_too_long_sat: assert property (@(posedge clk) disable iff (rst)
    frame_too_long |-> byte_position == POS_W'(FRAME_MAX))
    else $error("frame marked too long before saturation");

endmodule

`default_nettype wire

[rtl/stored_frame_checker.sv]
// Top level of the stored frame checker: channels, register port, result register.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+-----------
//   in_ch    | in  | data_byte, last                           | valid/ready
//   out_ch   | out | payload_valid/byte/offset, done_res,      | valid/ready
//            |     | status, payload_length                    |
//   apb      | in  | dest_capacity at byte address 0           | psel/penable
//
// The CRC step, header capture and status check sit between the record state
// and the result register, so one item enters per cycle while the result
// register can drain. The result item is registered and appears in the cycle
// after acceptance.
// Synchronous reset clears the record state, the result valid and sets
// dest_capacity to 4096. A stalled result blocks a new item only while the
// result register is full and not being taken.
`default_nettype none

module stored_frame_checker #(
  parameter int MAX_PAYLOAD = sfc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  sfc_in_if.sink                            in_ch,
  sfc_out_if.source                         out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sfc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sfc_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  logic                     dest_capacity;
  logic [sfc_pkg::CAP_W-1:0] cap_reg;
  logic                     accept;
  logic                     reg_hit;
  sfc_pkg::sfc_res_t        res;
  sfc_pkg::sfc_res_t        out_res;
  logic                     out_valid;

  // Register decode: the word index sits above the byte offset.
  assign reg_hit       = (paddr[2] == sfc_pkg::REG_DEST_CAPACITY);
  assign dest_capacity = reg_hit;
  assign pready        = 1'b1;
  assign prdata        = dest_capacity ? sfc_pkg::PDATA_W'(cap_reg) : '0;

  // Capacity register, written in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= sfc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cap_reg <= pwdata[sfc_pkg::CAP_W-1:0];
    end
  end

  // A new item enters whenever the result register is empty or draining.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sfc_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .last         (in_ch.last),
    .dest_capacity(cap_reg),
    .res          (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.payload_valid  = out_res.payload_valid;
  assign out_ch.payload_byte   = out_res.payload_byte;
  assign out_ch.payload_offset = out_res.payload_offset;
  assign out_ch.done_res       = out_res.done_res;
  assign out_ch.status         = out_res.status;
  assign out_ch.payload_length = out_res.payload_length;

  // Status and length are only reported on the last byte.
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |->
      out_res.status == sfc_pkg::ST_OK && out_res.payload_length == '0)
    else $error("status or length outside the last byte");

  // A forwarded last byte implies a good header and a sane frame size.
  a_fwd_header_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.payload_valid && out_res.done_res |->
      out_res.status != sfc_pkg::ST_SIZE && out_res.status != sfc_pkg::ST_HEADER)
    else $error("payload forwarded from a bad header");

  // A held result is not dropped while the consumer stalls.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid)
    else $error("result lost under stall");

endmodule

`default_nettype wire
